// File: hdl/dnsa_pkg.sv
// Shared constants and types for the DNS response A-record extractor.
package dnsa_pkg;

    localparam int MAX_PACKET_BYTES = 256;
    localparam int OFFSET_W         = $clog2(MAX_PACKET_BYTES + 1);
    localparam int HDR_BYTES        = 12;

    localparam logic [7:0]  PTR_MARK_BYTE = 8'hC0;
    localparam logic [15:0] ADDR_RDLEN    = 16'd4;
    localparam logic [31:0] TC_A_IN       = 32'h0001_0001;

    localparam logic RESULT_ADDR   = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_ID       = 3'd2;
    localparam logic [2:0] ST_NOT_RESP = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_TC       = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_IDX_TXID = 1'b0;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [2:0]  status;
        logic        last;
    } result_t;

endpackage

// File: hdl/dns_response_a_record_extractor.sv
// DNS response parser that extracts IPv4 addresses of A records, one byte per request.
//
// The block takes one datagram byte per cycle and never stalls on its own: every
// byte is parsed by the state update in the cycle it is accepted, and its results
// (an address, an end-of-packet status, or both on the final byte) are written into
// a four-entry output queue, which registers them. in_ready drops only while the
// queue holds more than two results, which happens when the downstream side stops
// taking them. The expected transaction ID is written over the APB port at byte
// address 0 and must be set while no datagram is in flight.
module dns_response_a_record_extractor (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        packet_byte,
    input  logic                              is_last_byte,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              result_kind,
    output logic [31:0]                       ipv4_address,
    output logic [2:0]                        packet_status,
    output logic                              last_of_run,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dnsa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam logic [3:0] PH_HEADER     = 4'd0;
    localparam logic [3:0] PH_QNAME      = 4'd1;
    localparam logic [3:0] PH_QTC        = 4'd2;
    localparam logic [3:0] PH_AN_FIRST   = 4'd3;
    localparam logic [3:0] PH_AN_PTR     = 4'd4;
    localparam logic [3:0] PH_AN_LABELS  = 4'd5;
    localparam logic [3:0] PH_AN_TC      = 4'd6;
    localparam logic [3:0] PH_AN_TTL     = 4'd7;
    localparam logic [3:0] PH_AN_RDLEN   = 4'd8;
    localparam logic [3:0] PH_RDATA_ADDR = 4'd9;
    localparam logic [3:0] PH_RDATA_SKIP = 4'd10;
    localparam logic [3:0] PH_IGNORE     = 4'd11;

    localparam int OW = dnsa_pkg::OFFSET_W;
    localparam int PW = dnsa_pkg::OUTQ_PTR_W;
    localparam int CW = dnsa_pkg::OUTQ_CNT_W;

    logic [15:0]   txid_reg;

    logic [3:0]    phase_reg, phase_next;
    logic [OW-1:0] offset_reg, offset_next;
    logic [15:0]   fcnt_reg, fcnt_next;
    logic [31:0]   asm_reg, asm_next;
    logic [31:0]   qtc_reg, qtc_next;
    logic [31:0]   atc_reg, atc_next;
    logic [2:0]    err_reg, err_next;

    dnsa_pkg::result_t outq_reg [dnsa_pkg::OUTQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] qcnt_reg, qcnt_next;

    logic          accept;
    logic          pop;
    logic          in_range;
    logic [31:0]   asm_shift;
    logic [15:0]   fcnt_inc;
    logic [15:0]   fcnt_dec;
    logic [15:0]   rdlen;
    logic          push_addr;
    logic          push_status;
    logic [31:0]   addr_value;
    logic [2:0]    status_value;
    logic [PW-1:0] status_slot;
    logic          cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == dnsa_pkg::CFG_IDX_TXID) ? {16'd0, txid_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txid_reg <= 16'd0;
        end
        else if (cfg_write && paddr[2] == dnsa_pkg::CFG_IDX_TXID)
        begin
            txid_reg <= pwdata[15:0];
        end
    end

    // Handshakes
    assign in_ready  = (qcnt_reg <= CW'(dnsa_pkg::OUTQ_DEPTH - 2));
    assign accept    = in_valid && in_ready;
    assign out_valid = (qcnt_reg != '0);
    assign pop       = out_valid && out_ready;

    assign in_range  = (offset_reg < OW'(dnsa_pkg::MAX_PACKET_BYTES));
    assign asm_shift = {asm_reg[23:0], packet_byte};
    assign fcnt_inc  = fcnt_reg + 16'd1;
    assign fcnt_dec  = fcnt_reg - 16'd1;
    assign rdlen     = {asm_reg[7:0], packet_byte};

    // Parser state update for one accepted byte
    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        fcnt_next    = fcnt_reg;
        asm_next     = asm_reg;
        qtc_next     = qtc_reg;
        atc_next     = atc_reg;
        err_next     = err_reg;
        push_addr    = 1'b0;
        push_status  = 1'b0;
        addr_value   = asm_shift;
        status_value = dnsa_pkg::ST_OK;

        if (accept && in_range)
        begin
            offset_next = offset_reg + OW'(1);
            case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == OW'(0))
                    begin
                        asm_next = {24'd0, packet_byte};
                    end
                    else if (offset_reg == OW'(1))
                    begin
                        if ({asm_reg[7:0], packet_byte} != txid_reg)
                        begin
                            err_next   = dnsa_pkg::ST_ID;
                            phase_next = PH_IGNORE;
                        end
                    end
                    else if (offset_reg == OW'(2))
                    begin
                        if (!packet_byte[7])
                        begin
                            err_next   = dnsa_pkg::ST_NOT_RESP;
                            phase_next = PH_IGNORE;
                        end
                    end
                    else if (offset_reg == OW'(dnsa_pkg::HDR_BYTES - 1))
                    begin
                        phase_next = PH_QNAME;
                    end
                end
                PH_QNAME:
                begin
                    if (packet_byte == 8'd0)
                    begin
                        phase_next = PH_QTC;
                        fcnt_next  = 16'd0;
                        asm_next   = 32'd0;
                    end
                end
                PH_QTC:
                begin
                    if (fcnt_inc == 16'd4)
                    begin
                        qtc_next   = asm_shift;
                        phase_next = PH_AN_FIRST;
                        fcnt_next  = 16'd0;
                        asm_next   = 32'd0;
                    end
                    else
                    begin
                        fcnt_next = fcnt_inc;
                        asm_next  = asm_shift;
                    end
                end
                PH_AN_FIRST:
                begin
                    if (packet_byte == dnsa_pkg::PTR_MARK_BYTE)
                    begin
                        phase_next = PH_AN_PTR;
                    end
                    else if (packet_byte == 8'd0)
                    begin
                        phase_next = PH_AN_TC;
                        fcnt_next  = 16'd0;
                        asm_next   = 32'd0;
                    end
                    else
                    begin
                        phase_next = PH_AN_LABELS;
                    end
                end
                PH_AN_PTR:
                begin
                    phase_next = PH_AN_TC;
                    fcnt_next  = 16'd0;
                    asm_next   = 32'd0;
                end
                PH_AN_LABELS:
                begin
                    if (packet_byte == 8'd0)
                    begin
                        phase_next = PH_AN_TC;
                        fcnt_next  = 16'd0;
                        asm_next   = 32'd0;
                    end
                end
                PH_AN_TC:
                begin
                    fcnt_next = fcnt_inc;
                    asm_next  = asm_shift;
                    if (fcnt_inc == 16'd4)
                    begin
                        atc_next = asm_shift;
                        if (asm_shift != qtc_reg)
                        begin
                            err_next   = dnsa_pkg::ST_TC;
                            phase_next = PH_IGNORE;
                        end
                        else
                        begin
                            phase_next = PH_AN_TTL;
                            fcnt_next  = 16'd0;
                            asm_next   = 32'd0;
                        end
                    end
                end
                PH_AN_TTL:
                begin
                    if (fcnt_inc == 16'd4)
                    begin
                        phase_next = PH_AN_RDLEN;
                        fcnt_next  = 16'd0;
                        asm_next   = 32'd0;
                    end
                    else
                    begin
                        fcnt_next = fcnt_inc;
                    end
                end
                PH_AN_RDLEN:
                begin
                    if (fcnt_inc == 16'd2)
                    begin
                        asm_next = 32'd0;
                        if (rdlen == 16'd0)
                        begin
                            phase_next = PH_AN_FIRST;
                            fcnt_next  = 16'd0;
                        end
                        else
                        begin
                            // The data length becomes the down-counter for the data bytes.
                            fcnt_next = rdlen;
                            if (rdlen == dnsa_pkg::ADDR_RDLEN && atc_reg == dnsa_pkg::TC_A_IN)
                            begin
                                phase_next = PH_RDATA_ADDR;
                            end
                            else
                            begin
                                phase_next = PH_RDATA_SKIP;
                            end
                        end
                    end
                    else
                    begin
                        fcnt_next = fcnt_inc;
                        asm_next  = {16'd0, rdlen};
                    end
                end
                PH_RDATA_ADDR, PH_RDATA_SKIP:
                begin
                    fcnt_next = fcnt_dec;
                    asm_next  = asm_shift;
                    if (fcnt_dec == 16'd0)
                    begin
                        push_addr  = (phase_reg == PH_RDATA_ADDR);
                        phase_next = PH_AN_FIRST;
                        asm_next   = 32'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (accept && is_last_byte)
        begin
            push_status = 1'b1;
            if (offset_next <= OW'(dnsa_pkg::HDR_BYTES))
            begin
                status_value = dnsa_pkg::ST_SHORT;
            end
            else if (err_next != dnsa_pkg::ST_OK)
            begin
                status_value = err_next;
            end
            else if (phase_next == PH_AN_FIRST)
            begin
                status_value = dnsa_pkg::ST_OK;
            end
            else
            begin
                status_value = dnsa_pkg::ST_TRUNC;
            end
            phase_next  = PH_HEADER;
            offset_next = '0;
            fcnt_next   = 16'd0;
            asm_next    = 32'd0;
            qtc_next    = 32'd0;
            atc_next    = 32'd0;
            err_next    = dnsa_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            fcnt_reg   <= 16'd0;
            asm_reg    <= 32'd0;
            qtc_reg    <= 32'd0;
            atc_reg    <= 32'd0;
            err_reg    <= dnsa_pkg::ST_OK;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            fcnt_reg   <= fcnt_next;
            asm_reg    <= asm_next;
            qtc_reg    <= qtc_next;
            atc_reg    <= atc_next;
            err_reg    <= err_next;
        end
    end

    // Output queue: up to two results enter per request, one leaves per cycle while out_ready is high.
    assign status_slot = push_addr ? (wr_ptr_reg + PW'(1)) : wr_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_addr) + PW'(push_status);
        rd_ptr_next = pop ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        qcnt_next   = qcnt_reg + CW'(push_addr) + CW'(push_status) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_addr)
        begin
            outq_reg[wr_ptr_reg] <= '{kind:   dnsa_pkg::RESULT_ADDR,
                                      addr:   addr_value,
                                      status: dnsa_pkg::ST_OK,
                                      last:   !push_status};
        end
        if (push_status)
        begin
            outq_reg[status_slot] <= '{kind:   dnsa_pkg::RESULT_STATUS,
                                       addr:   32'd0,
                                       status: status_value,
                                       last:   1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            qcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            qcnt_reg   <= qcnt_next;
        end
    end

    assign result_kind   = outq_reg[rd_ptr_reg].kind;
    assign ipv4_address  = outq_reg[rd_ptr_reg].addr;
    assign packet_status = outq_reg[rd_ptr_reg].status;
    assign last_of_run   = outq_reg[rd_ptr_reg].last;

endmodule

// File: hdl/dnsa_checker.sv
// Port-level assertions for the DNS response A-record extractor, bound to the top level.
module dnsa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        result_kind,
    input  logic [31:0] ipv4_address,
    input  logic [2:0]  packet_status,
    input  logic        last_of_run
);

    // A waiting result keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(ipv4_address) && $stable(packet_status) && $stable(last_of_run))
        else $error("result changed while stalled");

    // A status always closes the run of results caused by one byte.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == dnsa_pkg::RESULT_STATUS |->
            last_of_run && ipv4_address == 32'd0)
        else $error("status result not marked last or carries an address");

    // An address that is not last is followed at once by the status of the same byte.
    a_addr_then_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && result_kind == dnsa_pkg::RESULT_ADDR && !last_of_run |=>
            out_valid && result_kind == dnsa_pkg::RESULT_STATUS)
        else $error("address without last mark not followed by status");

    // Address results carry no status, and status codes stay in their range.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == dnsa_pkg::RESULT_STATUS
            ? packet_status <= dnsa_pkg::ST_TC : packet_status == dnsa_pkg::ST_OK))
        else $error("packet status out of range");

endmodule

bind dns_response_a_record_extractor dnsa_checker u_dnsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .ipv4_address  (ipv4_address),
    .packet_status (packet_status),
    .last_of_run   (last_of_run)
);
